@@ design/htc_pkg.sv @@
// htc_pkg: shared types and constants of the hierarchy transitive closure block
// function codes, stream widths and the controller-to-datapath command struct
// no dependencies
`default_nettype none

package htc_pkg;

    // node count default and fixed field widths
    localparam int NODES_DEFAULT = 32;
    localparam int NODE_FIELD_W  = 5;
    localparam int FUNC_W        = 2;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 8;

    // function codes carried in tuser
    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_CLOSE = 2'd2,
        FUNC_QUERY = 2'd3
    } func_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // input word taken this cycle
        logic step;     // one pivot step of the closure
        logic finish;   // load the close result into the output register
    } ctrl_cmd_t;

endpackage

`default_nettype wire

@@ design/htc_ctrl.sv @@
// htc_ctrl: controller of the hierarchy transitive closure block
// handshake control, close sequencing with pivot counter, output valid
// depends on htc_pkg
`default_nettype none

module htc_ctrl #(
    parameter int NODES = htc_pkg::NODES_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire htc_pkg::func_t             func,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output htc_pkg::ctrl_cmd_t              cmd,
    output logic [$clog2(NODES)-1:0]        pivot
);
    import htc_pkg::*;

    localparam int NODE_W = $clog2(NODES);
    localparam logic [NODE_W-1:0] LAST_PIVOT = NODE_W'(NODES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [NODE_W-1:0] pivot_reg, pivot_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;
    logic              load_out;

    // output slot can take a word when empty or being drained
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;

    // command decode
    always_comb
    begin
        cmd.accept = s_valid && s_ready;
        cmd.step   = (state_reg == ST_CLOSE);
        cmd.finish = (state_reg == ST_DONE) && out_free;
        load_out   = (cmd.accept && (func != FUNC_CLOSE)) || cmd.finish;
    end

    // next state, pivot and output valid
    always_comb
    begin
        state_next = state_reg;
        pivot_next = pivot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && (func == FUNC_CLOSE))
                begin
                    state_next = ST_CLOSE;
                    pivot_next = '0;
                end
            end
            ST_CLOSE:
            begin
                if (pivot_reg == LAST_PIVOT)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    pivot_next = pivot_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        priority if (load_out)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pivot_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pivot_reg   <= pivot_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign pivot   = pivot_reg;

endmodule

`default_nettype wire

@@ design/htc_datapath.sv @@
// htc_datapath: edge store, reachability rows and result register
// row-parallel pivot update driven by the controller commands
// depends on htc_pkg
`default_nettype none

module htc_datapath #(
    parameter int NODES = htc_pkg::NODES_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire htc_pkg::ctrl_cmd_t                cmd,
    input  wire logic [$clog2(NODES)-1:0]          pivot,
    input  wire htc_pkg::func_t                    func,
    input  wire logic [htc_pkg::NODE_FIELD_W-1:0]  src_node,
    input  wire logic [htc_pkg::NODE_FIELD_W-1:0]  dst_node,
    output logic                                   reachable,
    output htc_pkg::func_t                         func_done
);
    import htc_pkg::*;

    localparam int NODE_W = $clog2(NODES);

    logic [NODES-1:0]  edge_rows_reg  [NODES];
    logic [NODES-1:0]  edge_rows_next [NODES];
    logic [NODES-1:0]  reach_rows_reg  [NODES];
    logic [NODES-1:0]  reach_rows_next [NODES];
    logic [NODE_W-1:0] src_idx;
    logic [NODE_W-1:0] dst_idx;
    logic [NODE_W-1:0] row_sel;
    logic [NODES-1:0]  sel_row;
    logic              in_range;
    logic              answer;
    logic              reachable_reg, reachable_next;
    func_t             func_done_reg, func_done_next;

    // node indices and range check
    assign in_range = (32'(src_node) < NODES) && (32'(dst_node) < NODES);
    assign src_idx  = NODE_W'(src_node);
    assign dst_idx  = NODE_W'(dst_node);

    // one shared row read: pivot row during a close, source row otherwise
    assign row_sel = cmd.step ? pivot : src_idx;
    assign sel_row = reach_rows_reg[row_sel];
    assign answer  = (src_node == dst_node) || (in_range && sel_row[dst_idx]);

    // edge store update
    always_comb
    begin
        edge_rows_next = edge_rows_reg;
        if (cmd.accept)
        begin
            if (func == FUNC_CLEAR)
            begin
                for (int i = 0; i < NODES; i++)
                begin
                    edge_rows_next[i] = '0;
                end
            end
            else if ((func == FUNC_ADD) && in_range)
            begin
                edge_rows_next[src_idx][dst_idx] = 1'b1;
            end
        end
    end

    // reachability rows: copy on close, then one pivot per step
    always_comb
    begin
        reach_rows_next = reach_rows_reg;
        if (cmd.accept && (func == FUNC_CLOSE))
        begin
            reach_rows_next = edge_rows_reg;
        end
        else if (cmd.step)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                if (reach_rows_reg[i][pivot])
                begin
                    reach_rows_next[i] = reach_rows_reg[i] | sel_row;
                end
            end
        end
    end

    // result payload
    always_comb
    begin
        reachable_next = reachable_reg;
        func_done_next = func_done_reg;
        if (cmd.finish)
        begin
            reachable_next = 1'b0;
            func_done_next = FUNC_CLOSE;
        end
        else if (cmd.accept && (func != FUNC_CLOSE))
        begin
            reachable_next = (func == FUNC_QUERY) && answer;
            func_done_next = func;
        end
    end

    // edge and reachability storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                edge_rows_reg[i]  <= '0;
                reach_rows_reg[i] <= '0;
            end
        end
        else
        begin
            edge_rows_reg  <= edge_rows_next;
            reach_rows_reg <= reach_rows_next;
        end
    end

    // result register, payload only
    always_ff @(posedge clk)
    begin
        reachable_reg <= reachable_next;
        func_done_reg <= func_done_next;
    end

    assign reachable = reachable_reg;
    assign func_done = func_done_reg;

endmodule

`default_nettype wire

@@ design/hierarchy_transitive_closure_top.sv @@
// hierarchy_transitive_closure_top: top level of the hierarchy reachability block
// joins the controller and the datapath to the stream ports
// depends on htc_pkg, htc_ctrl, htc_datapath
`default_nettype none

// Keeps a store of directed is-a edges between NODES numbered nodes and a
// separate reachability matrix that is refreshed only by a close. Clear, add
// and query words can follow one another every cycle while the output drains;
// their results go to an output register, so a new word is taken while a
// result waits as long as the register is drained in the same cycle. A close
// copies the edges into the matrix as it is taken, then runs NODES pivot
// steps in which every row is updated in parallel from the pivot row, and
// then hands over the result; input is held off meanwhile. Both matrices are
// cleared directly by reset, with no clearing pass.
module hierarchy_transitive_closure_top #(
    parameter int NODES = htc_pkg::NODES_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [4:0] src_node, [9:5] dst_node, [15:10] zero
    input  wire logic [htc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] func
    input  wire logic [htc_pkg::FUNC_W-1:0]    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [0] reachable, [7:1] zero
    output logic [htc_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // [1:0] func_done
    output logic [htc_pkg::FUNC_W-1:0]         m_axis_tuser
);
    import htc_pkg::*;

    localparam int NODE_W = $clog2(NODES);

    ctrl_cmd_t                cmd;
    logic [NODE_W-1:0]        pivot;
    func_t                    func;
    func_t                    func_done;
    logic                     reachable;
    logic [NODE_FIELD_W-1:0]  src_node;
    logic [NODE_FIELD_W-1:0]  dst_node;

    // unpack the input word
    assign func     = func_t'(s_axis_tuser);
    assign src_node = s_axis_tdata[NODE_FIELD_W-1:0];
    assign dst_node = s_axis_tdata[2*NODE_FIELD_W-1:NODE_FIELD_W];

    htc_ctrl #(
        .NODES (NODES)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .func    (func),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd),
        .pivot   (pivot)
    );

    htc_datapath #(
        .NODES (NODES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .pivot     (pivot),
        .func      (func),
        .src_node  (src_node),
        .dst_node  (dst_node),
        .reachable (reachable),
        .func_done (func_done)
    );

    // pack the result word
    assign m_axis_tdata = {{(M_TDATA_W-1){1'b0}}, reachable};
    assign m_axis_tuser = func_done;

endmodule

`default_nettype wire

@@ design/htc_checker.sv @@
// htc_checker: port-level assertions for the hierarchy reachability block
// bound to hierarchy_transitive_closure_top, depends on htc_pkg
`default_nettype none

module htc_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic [htc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input wire logic [htc_pkg::FUNC_W-1:0]    s_axis_tuser,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [htc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [htc_pkg::FUNC_W-1:0]    m_axis_tuser
);
    import htc_pkg::*;

    logic s_take;
    logic out_free;

    assign s_take   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_axis_tvalid || m_axis_tready;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // only a query can report reachable, and a non-query result word is all zero
    a_nonquery_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != FUNC_QUERY) |->
            (m_axis_tdata == '0))
        else $error("non-query result carries data");

    // a query of a node against itself answers true in the next cycle
    a_self_query: assert property (@(posedge clk) disable iff (!rst_n)
        s_take && out_free && (s_axis_tuser == FUNC_QUERY) &&
            (s_axis_tdata[4:0] == s_axis_tdata[9:5]) |=>
            m_axis_tvalid && (m_axis_tuser == FUNC_QUERY) && m_axis_tdata[0])
        else $error("self query did not answer true");

    // a close holds off input in the following cycle
    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_take && (s_axis_tuser == FUNC_CLOSE) |=> !s_axis_tready)
        else $error("input taken during a close");

    // a clear, add or query with room at the output gives its result next
    a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_take && out_free && (s_axis_tuser != FUNC_CLOSE) |=>
            m_axis_tvalid && (m_axis_tuser == $past(s_axis_tuser)))
        else $error("result of a single-cycle function missing");

endmodule

bind hierarchy_transitive_closure_top htc_checker u_htc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/tb_hierarchy_transitive_closure_top.sv @@
// tb_hierarchy_transitive_closure_top: stream testbench of the hierarchy reachability block
// predicts every result word from its own edge and closure stores and checks them in order
// depends on htc_pkg and hierarchy_transitive_closure_top
`default_nettype none

module tb_hierarchy_transitive_closure_top;
    timeunit 1ns;
    timeprecision 1ps;

    import htc_pkg::*;

    localparam int NODES        = NODES_DEFAULT;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 420;

    // one predicted result word
    typedef struct packed {
        logic  reachable;
        func_t func_done;
    } reach_answer_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [FUNC_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [FUNC_W-1:0]     m_axis_tuser;

    // predictor state
    logic [NODES-1:0]      edge_store    [NODES];
    logic [NODES-1:0]      closure_store [NODES];
    reach_answer_t         pending_answers[$];

    int                    send_idle_pct = 0;
    int                    ready_stall_pct = 0;
    int                    items_sent = 0;
    int                    mismatches = 0;
    int                    failures = 0;

    hierarchy_transitive_closure_top #(
        .NODES(NODES)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // clear both stores as reset does
    function automatic void reset_stores();
        for (int i = 0; i < NODES; i++)
        begin
            edge_store[i]    = '0;
            closure_store[i] = '0;
        end
    endfunction

    // apply one accepted word to the stores and return its answer
    function automatic reach_answer_t compute_answer(func_t func, int src, int dst);
        reach_answer_t    ans;
        logic [NODES-1:0] pivot;
        bit               in_range;
        in_range      = (src < NODES) && (dst < NODES);
        ans.reachable = 1'b0;
        ans.func_done = func;
        case (func)
            FUNC_CLEAR:
                for (int i = 0; i < NODES; i++)
                    edge_store[i] = '0;
            FUNC_ADD:
                if (in_range)
                    edge_store[src][dst] = 1'b1;
            FUNC_CLOSE:
            begin
                for (int i = 0; i < NODES; i++)
                    closure_store[i] = edge_store[i];
                // warshall: each pivot row spreads into every row that reaches it
                for (int k = 0; k < NODES; k++)
                begin
                    pivot = closure_store[k];
                    for (int i = 0; i < NODES; i++)
                        if (closure_store[i][k])
                            closure_store[i] = closure_store[i] | pivot;
                end
            end
            default:
                if (src == dst)
                    ans.reachable = 1'b1;
                else if (in_range && closure_store[src][dst])
                    ans.reachable = 1'b1;
        endcase
        return ans;
    endfunction

    // count a failure, report the first few
    task automatic note_mismatch(string what, logic [M_TDATA_W-1:0] exp_data,
                                 logic [FUNC_W-1:0] exp_user);
        mismatches++;
        failures++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch (%s) at %0t: expected tdata=%h tuser=%0d, got tdata=%h tuser=%0d",
                     what, $realtime, exp_data, exp_user, m_axis_tdata, m_axis_tuser);
    endtask

    // send one word and predict its answer once it is taken
    task automatic send_word(func_t func, int src, int dst);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {{(S_TDATA_W - 2 * NODE_FIELD_W){1'b0}},
                          NODE_FIELD_W'(dst), NODE_FIELD_W'(src)};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_answers = {pending_answers, compute_answer(func, src, dst)};
        items_sent++;
    endtask

    // hold the sender until every predicted word has come back
    task automatic wait_answers_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_answers.size() != 0);
    endtask

    // receiver side stalls
    initial
    begin
        forever
        begin
            @(posedge clk);
            m_axis_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
        end
    end

    // compare each result word with the oldest prediction
    initial
    begin
        reach_answer_t want;
        logic [M_TDATA_W-1:0] want_data;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (pending_answers.size() == 0)
                    note_mismatch("no word expected", '0, '0);
                else
                begin
                    want      = pending_answers.pop_front();
                    want_data = {{(M_TDATA_W - 1){1'b0}}, want.reachable};
                    if (m_axis_tdata !== want_data || m_axis_tuser !== want.func_done)
                        note_mismatch("field", want_data, want.func_done);
                end
            end
        end
    end

    // queries straight after reset see an empty closure
    task automatic test_empty_closure();
        send_word(FUNC_QUERY, 0, 0);
        send_word(FUNC_QUERY, 31, 31);
        send_word(FUNC_QUERY, 0, 31);
        send_word(FUNC_QUERY, 31, 0);
        send_word(FUNC_CLOSE, 0, 0);
        send_word(FUNC_QUERY, 5, 6);
    endtask

    // chain through the extreme nodes, a cycle, a self edge and a repeated edge
    task automatic test_chain_and_cycles();
        send_word(FUNC_ADD, 0, 1);
        send_word(FUNC_ADD, 1, 2);
        send_word(FUNC_ADD, 2, 31);
        send_word(FUNC_ADD, 31, 0);
        send_word(FUNC_ADD, 31, 0);
        send_word(FUNC_ADD, 7, 7);
        // stale matrix until the next close
        send_word(FUNC_QUERY, 0, 31);
        send_word(FUNC_CLOSE, 31, 31);
        send_word(FUNC_QUERY, 0, 31);
        send_word(FUNC_QUERY, 31, 2);
        send_word(FUNC_QUERY, 7, 7);
        send_word(FUNC_QUERY, 7, 8);
        send_word(FUNC_QUERY, 3, 0);
    endtask

    // clear touches only the edges, the closure holds until the next close
    task automatic test_clear_keeps_closure();
        send_word(FUNC_CLEAR, 31, 31);
        send_word(FUNC_QUERY, 0, 2);
        send_word(FUNC_CLOSE, 0, 0);
        send_word(FUNC_QUERY, 0, 2);
    endtask

    // random graphs: clear, edges inside a node pool, close, queries; some noise
    task automatic test_random_graphs(int count);
        int stop_at;
        int pool_base;
        int pool_size;
        int n_edges;
        int n_queries;
        int src;
        int dst;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                // noise: any word kind, any nodes
                repeat ($urandom_range(1, 8))
                    send_word(func_t'($urandom_range(0, 3)),
                              $urandom_range(0, 31), $urandom_range(0, 31));
            end
            else
            begin
                pool_base = $urandom_range(0, 31);
                pool_size = $urandom_range(2, 32);
                n_edges   = $urandom_range(1, pool_size + 8);
                n_queries = $urandom_range(4, 24);
                if ($urandom_range(0, 9) != 0)
                    send_word(FUNC_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31));
                repeat (n_edges)
                    send_word(FUNC_ADD, (pool_base + $urandom_range(0, pool_size - 1)) % 32,
                              (pool_base + $urandom_range(0, pool_size - 1)) % 32);
                send_word(FUNC_CLOSE, $urandom_range(0, 31), $urandom_range(0, 31));
                // a few edges after the close leave the matrix stale
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 4))
                        send_word(FUNC_ADD, (pool_base + $urandom_range(0, pool_size - 1)) % 32,
                                  (pool_base + $urandom_range(0, pool_size - 1)) % 32);
                repeat (n_queries)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        src = $urandom_range(0, 31);
                        dst = src;
                    end
                    else if ($urandom_range(0, 9) < 7)
                    begin
                        src = (pool_base + $urandom_range(0, pool_size - 1)) % 32;
                        dst = (pool_base + $urandom_range(0, pool_size - 1)) % 32;
                    end
                    else
                    begin
                        src = $urandom_range(0, 31);
                        dst = $urandom_range(0, 31);
                    end
                    send_word(FUNC_QUERY, src, dst);
                end
            end
            if ($urandom_range(0, 9) == 0)
                wait_answers_drained();
        end
        wait_answers_drained();
    endtask

    // main sequence
    initial
    begin
        reset_stores();
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_closure();
        test_chain_and_cycles();
        test_clear_keeps_closure();
        wait_answers_drained();

        // no idling on either side
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        test_random_graphs(PHASE_ITEMS);

        // sender mostly idle
        send_idle_pct   = 85;
        ready_stall_pct = 0;
        test_random_graphs(PHASE_ITEMS);

        // receiver mostly stalling
        send_idle_pct   = 0;
        ready_stall_pct = 85;
        test_random_graphs(PHASE_ITEMS);

        // light idling on both sides
        send_idle_pct   = 12;
        ready_stall_pct = 12;
        test_random_graphs(PHASE_ITEMS);

        // let any stray word show up after the last close
        ready_stall_pct = 0;
        repeat (NODES + 16) @(posedge clk);
        failures += pending_answers.size();

        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
